// ----- sv/knp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// knp2d_pkg
// Shared types and constants for the 2D k-nearest-points block.
// ----------------------------------------------------------------------------
package knp2d_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int DIST_W = 33;

   typedef struct packed {
      logic               op;
      logic               first;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [5:0]         key_index;
      logic [6:0]         want_count;
   } req_type;

   typedef struct packed {
      logic [5:0]         rank;
      logic signed [15:0] near_x;
      logic signed [15:0] near_y;
      logic [32:0]        dist_sq;
      logic               is_infinite;
      logic               last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // write the request point into the store
      logic key_cap;     // capture key read data
      logic scan_start;  // clear best-so-far for a new selection pass
      logic scan_eval;   // compare the read point with best-so-far
      logic emit_cap;    // capture the chosen point into the output register
   } cmd_type;

   // Datapath status back to controller
   typedef struct packed {
      logic rsp_busy;    // output register still holds an untaken result
   } sts_type;

endpackage

// ----- sv/k_nearest_points_2d.sv -----
// ----------------------------------------------------------------------------
// k_nearest_points_2d
// Brute-force k nearest points in the plane over a stored point set.
// ----------------------------------------------------------------------------
// A load request stores one point. A query reads the key point, then runs one
// selection pass over all N stored points per reported point, through the single
// read port of the point memory; while a query runs, no new request is taken.
// Results come out nearest first; points equal to the key come last with
// is_infinite set.
module k_nearest_points_2d
   import knp2d_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = 6;

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] wr_idx, rd_idx, rank, best_idx;
   logic             last;

   knp2d_ctrl #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data, .sts, .best_idx,
      .cmd, .wr_idx, .rd_idx, .rank, .last
   );

   knp2d_datapath #(.IDX_W(IDX_W)) u_dp (
      .clock, .reset, .cmd, .req(req_data), .wr_idx, .rd_idx, .rank, .last,
      .best_idx, .sts, .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// ----- sv/knp2d_datapath.sv -----
// ----------------------------------------------------------------------------
// knp2d_datapath
// Point store, squared-distance unit, best-candidate selection and output reg.
// ----------------------------------------------------------------------------
module knp2d_datapath
   import knp2d_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic [IDX_W-1:0] rank,
   input  logic             last,
   // current best candidate index, read back to emit the chosen point
   output logic [IDX_W-1:0] best_idx,
   output sts_type          sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int DEPTH = 1 << IDX_W;

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic signed [15:0] kx_ff, ky_ff;
   // threshold: last emitted (inf, dist, idx); thr_vld_ff means one exists
   logic               thr_vld_ff, thr_inf_ff;
   logic [DIST_W-1:0]  thr_d_ff;
   logic [IDX_W-1:0]   thr_i_ff;
   logic               bst_vld_ff, bst_inf_ff;
   logic [DIST_W-1:0]  bst_d_ff;
   logic [IDX_W-1:0]   bst_i_ff;
   rsp_type            rsp_ff;
   logic               rsp_vld_ff;

   // store and registered read
   always_ff @(posedge clock) begin
      if (cmd.load) mem_ff[wr_idx] <= {req.x, req.y};
      rd_ff     <= mem_ff[rd_idx];
      rd_idx_ff <= rd_idx;
   end

   // distance of the read point to the key
   logic signed [16:0] dx, dy;
   logic [33:0]        dx2, dy2;
   logic [DIST_W-1:0]  p_dist;
   logic               p_inf;
   assign dx     = 17'(signed'(rd_ff[31:16])) - 17'(kx_ff);
   assign dy     = 17'(signed'(rd_ff[15:0]))  - 17'(ky_ff);
   assign dx2    = 34'(dx * dx);
   assign dy2    = 34'(dy * dy);
   assign p_dist = DIST_W'(dx2 + dy2);
   assign p_inf  = (rd_ff[31:16] == kx_ff) && (rd_ff[15:0] == ky_ff);

   // order key compare: a before b (inf, dist, index)
   function automatic logic before_k(logic ia, logic [DIST_W-1:0] da,
         logic [IDX_W-1:0] xa, logic ib, logic [DIST_W-1:0] db,
         logic [IDX_W-1:0] xb);
      if (ia != ib) return ib;
      if (!ia && da != db) return da < db;
      return xa < xb;
   endfunction

   logic after_thr, beats_bst;
   assign after_thr = !thr_vld_ff ||
                      before_k(thr_inf_ff, thr_d_ff, thr_i_ff, p_inf, p_dist, rd_idx_ff);
   assign beats_bst = !bst_vld_ff ||
                      before_k(p_inf, p_dist, rd_idx_ff, bst_inf_ff, bst_d_ff, bst_i_ff);

   // selection registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_vld_ff <= 1'b0;
         bst_vld_ff <= 1'b0;
      end else begin
         if (cmd.key_cap) begin
            kx_ff <= signed'(rd_ff[31:16]);
            ky_ff <= signed'(rd_ff[15:0]);
            thr_vld_ff <= 1'b0;
         end
         if (cmd.scan_start) bst_vld_ff <= 1'b0;
         if (cmd.scan_eval && after_thr && beats_bst) begin
            bst_vld_ff <= 1'b1;
            bst_inf_ff <= p_inf;
            bst_d_ff   <= p_dist;
            bst_i_ff   <= rd_idx_ff;
         end
         if (cmd.emit_cap) begin
            thr_vld_ff <= 1'b1;
            thr_inf_ff <= bst_inf_ff;
            thr_d_ff   <= bst_d_ff;
            thr_i_ff   <= bst_i_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (cmd.emit_cap) rsp_vld_ff <= 1'b1;
      else if (!rsp_stall) rsp_vld_ff <= 1'b0;
      if (cmd.emit_cap) begin
         rsp_ff.rank        <= 6'(rank);
         rsp_ff.near_x      <= signed'(rd_ff[31:16]);
         rsp_ff.near_y      <= signed'(rd_ff[15:0]);
         rsp_ff.dist_sq     <= bst_inf_ff ? '0 : bst_d_ff;
         rsp_ff.is_infinite <= bst_inf_ff;
         rsp_ff.last        <= last;
      end
   end

   assign best_idx     = bst_i_ff;
   assign sts.rsp_busy = rsp_vld_ff && rsp_stall;
   assign rsp_valid    = rsp_vld_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ----- sv/knp2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// knp2d_ctrl
// Sequencer: loads, key read, one selection scan per reported point.
// ----------------------------------------------------------------------------
module knp2d_ctrl
   import knp2d_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int IDX_W      = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  sts_type          sts,
   input  logic [IDX_W-1:0] best_idx,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] wr_idx,
   output logic [IDX_W-1:0] rd_idx,
   output logic [IDX_W-1:0] rank,
   output logic             last
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_KEY  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_ERD  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   localparam logic [IDX_W:0] MAXP = (IDX_W+1)'(MAX_POINTS);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W:0]   count_ff, count_in;
   logic [IDX_W:0]   k_ff, k_in;
   logic [IDX_W:0]   rank_ff, rank_in;
   logic [IDX_W:0]   scan_ff, scan_in;

   logic take, is_load, q_ok;
   logic [IDX_W:0] cnt_base, want_k;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign is_load   = (req_data.op == OP_LOAD);
   assign cnt_base  = req_data.first ? '0 : count_ff;
   assign want_k    = ((IDX_W+1)'(req_data.want_count) < count_ff) ?
                      (IDX_W+1)'(req_data.want_count) : count_ff;
   assign q_ok      = ((IDX_W+1)'(req_data.key_index) < count_ff) && (want_k != '0);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in     = k_ff;
      rank_in  = rank_ff;
      scan_in  = scan_ff;
      cmd      = '0;
      rd_idx   = scan_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            rd_idx = req_data.key_index[IDX_W-1:0];
            if (take && is_load) begin
               if (cnt_base < MAXP) begin
                  cmd.load = 1'b1;
                  count_in = cnt_base + 1'b1;
               end
            end else if (take && q_ok) begin
               k_in     = want_k;
               rank_in  = '0;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            cmd.key_cap    = 1'b1;
            cmd.scan_start = 1'b1;
            scan_in        = '0;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            // issue read of scan index; evaluate next cycle
            scan_in  = scan_ff + 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.scan_eval = 1'b1;
            if (scan_ff == count_ff) state_in = S_ERD;
            else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_EVAL;
            end
         end
         S_ERD: begin
            rd_idx = best_idx;
            if (!sts.rsp_busy) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_cap = 1'b1;
            rank_in      = rank_ff + 1'b1;
            if (rank_ff + 1'b1 == k_ff) state_in = S_IDLE;
            else begin
               cmd.scan_start = 1'b1;
               scan_in        = '0;
               state_in       = S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // S_SCAN and S_EVAL read through scan_ff; EVAL sees the previous read
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      k_ff    <= k_in;
      rank_ff <= rank_in;
      scan_ff <= scan_in;
   end

   assign wr_idx = cnt_base[IDX_W-1:0];
   assign rank   = rank_ff[IDX_W-1:0];
   assign last   = (rank_ff + 1'b1 == k_ff);

endmodule
